[rtl/core/pds_pkg.sv]
`timescale 1ns / 1ps

package pds_pkg;

  localparam int FREQ_W  = 32;
  localparam int MULT_W  = 10;
  localparam int PRE_W   = 16;
  localparam int POST_W  = 3;
  localparam int ERR_W   = 31;
  localparam int PROD_W  = 6;
  localparam int IDX_W   = 3;
  localparam int DVD_W   = 38;
  localparam int STEP_W  = 6;
  localparam int MUL_W   = FREQ_W + MULT_W;
  localparam int ALIGN_W = DVD_W - FREQ_W;

  localparam logic [STEP_W-1:0] STEPS_WIDE   = STEP_W'(DVD_W);
  localparam logic [STEP_W-1:0] STEPS_NARROW = STEP_W'(FREQ_W);

  localparam logic [POST_W-1:0] POST1_MIN = 3'd1;
  localparam logic [POST_W-1:0] POST1_MAX = 3'd7;
  localparam logic [POST_W-1:0] POST2_MIN = 3'd1;

  localparam logic [ERR_W-1:0] ERR_START = 31'h7FFF_FFFF;
  localparam logic [PRE_W-1:0] PRE_MAX   = 16'hFFFF;

  localparam logic [FREQ_W-1:0] RST_TARGET_MAX = 32'd200000000;
  localparam logic [FREQ_W-1:0] RST_TARGET_MIN = 32'd1875000;
  localparam logic [FREQ_W-1:0] RST_PLL_IN_MIN = 32'd8000000;
  localparam logic [FREQ_W-1:0] RST_PLL_IN_MAX = 32'd64000000;
  localparam logic [MULT_W-1:0] RST_MULT_MIN   = 10'd16;
  localparam logic [MULT_W-1:0] RST_MULT_MAX   = 10'd200;
  localparam logic [FREQ_W-1:0] RST_VCO_MIN    = 32'd400000000;
  localparam logic [FREQ_W-1:0] RST_VCO_MAX    = 32'd1600000000;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_PLL_IN = 2'd2,
    ST_NO_SOL = 2'd3
  } status_e;

  typedef enum logic [IDX_W-1:0] {
    REG_TARGET_MAX = 3'd0,
    REG_TARGET_MIN = 3'd1,
    REG_PLL_IN_MIN = 3'd2,
    REG_PLL_IN_MAX = 3'd3,
    REG_MULT_MIN   = 3'd4,
    REG_MULT_MAX   = 3'd5,
    REG_VCO_MIN    = 3'd6,
    REG_VCO_MAX    = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_PRE,
    S_FPL,
    S_MULT,
    S_DIVM,
    S_VCO,
    S_VCHK,
    S_DIVF,
    S_NEXT,
    S_OUT
  } seq_state_e;

  typedef struct packed {
    logic [FREQ_W-1:0] target_max;
    logic [FREQ_W-1:0] target_min;
    logic [FREQ_W-1:0] pll_in_min;
    logic [FREQ_W-1:0] pll_in_max;
    logic [MULT_W-1:0] mult_min;
    logic [MULT_W-1:0] mult_max;
    logic [FREQ_W-1:0] vco_min;
    logic [FREQ_W-1:0] vco_max;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [FREQ_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    status_e           status;
    logic [PRE_W-1:0]  pre_divider;
    logic [MULT_W-1:0] multiplier;
    logic [POST_W-1:0] post_div_first;
    logic [POST_W-1:0] post_div_second;
    logic [ERR_W-1:0]  freq_error;
  } result_t;

endpackage

[rtl/core/pds_regs.sv]
`timescale 1ns / 1ps

module pds_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pds_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [pds_pkg::FREQ_W-1:0] cfg_data_i,
  output pds_pkg::cfg_t              cfg_o
);

  pds_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (pds_pkg::reg_idx_e'(cfg_idx_i))
        pds_pkg::REG_TARGET_MAX: cfg_d.target_max = cfg_data_i;
        pds_pkg::REG_TARGET_MIN: cfg_d.target_min = cfg_data_i;
        pds_pkg::REG_PLL_IN_MIN: cfg_d.pll_in_min = cfg_data_i;
        pds_pkg::REG_PLL_IN_MAX: cfg_d.pll_in_max = cfg_data_i;
        pds_pkg::REG_MULT_MIN:   cfg_d.mult_min = cfg_data_i[pds_pkg::MULT_W-1:0];
        pds_pkg::REG_MULT_MAX:   cfg_d.mult_max = cfg_data_i[pds_pkg::MULT_W-1:0];
        pds_pkg::REG_VCO_MIN:    cfg_d.vco_min = cfg_data_i;
        pds_pkg::REG_VCO_MAX:    cfg_d.vco_max = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_max <= pds_pkg::RST_TARGET_MAX;
      cfg_q.target_min <= pds_pkg::RST_TARGET_MIN;
      cfg_q.pll_in_min <= pds_pkg::RST_PLL_IN_MIN;
      cfg_q.pll_in_max <= pds_pkg::RST_PLL_IN_MAX;
      cfg_q.mult_min   <= pds_pkg::RST_MULT_MIN;
      cfg_q.mult_max   <= pds_pkg::RST_MULT_MAX;
      cfg_q.vco_min    <= pds_pkg::RST_VCO_MIN;
      cfg_q.vco_max    <= pds_pkg::RST_VCO_MAX;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/pds_div.sv]
`timescale 1ns / 1ps

module pds_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pds_pkg::div_req_t req_i,
  output pds_pkg::div_rsp_t rsp_o
);

  localparam int DW = pds_pkg::DVD_W;
  localparam int VW = pds_pkg::FREQ_W;

  logic                       run_q, run_d;
  logic [pds_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]              dvd_q, dvd_d;
  logic [VW-1:0]              dvs_q, dvs_d;
  logic [VW-1:0]              rem_q, rem_d;
  logic [DW-1:0]              quo_q, quo_d;
  logic [VW:0]                trial;
  logic [VW:0]                diff;
  logic                       ge;
  logic                       done;

  // restoring radix-2 step: one quotient bit per cycle
  assign trial = {rem_q, dvd_q[DW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign done  = run_q && (cnt_q == '0);

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    dvs_d = dvs_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = req_i.steps;
      dvd_d = req_i.dividend;
      dvs_d = req_i.divisor;
      rem_d = '0;
      quo_d = '0;
    end else if (done) begin
      run_d = 1'b0;
    end else if (run_q) begin
      cnt_d = cnt_q - 1'b1;
      dvd_d = {dvd_q[DW-2:0], 1'b0};
      rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
      quo_d = {quo_q[DW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done;
  assign rsp_o.quotient = quo_q;

endmodule

[rtl/core/pds_seq.sv]
`timescale 1ns / 1ps

module pds_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pds_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [pds_pkg::FREQ_W-1:0] src_i,
  input  logic [pds_pkg::FREQ_W-1:0] tgt_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pds_pkg::result_t           res_o,
  output pds_pkg::div_req_t          div_req_o,
  input  pds_pkg::div_rsp_t          div_rsp_i
);

  localparam int FW = pds_pkg::FREQ_W;
  localparam int MW = pds_pkg::MULT_W;
  localparam int PW = pds_pkg::POST_W;
  localparam int EW = pds_pkg::ERR_W;
  localparam int DW = pds_pkg::DVD_W;
  localparam int XW = pds_pkg::MUL_W;

  pds_pkg::seq_state_e state_q, state_d;

  logic [FW-1:0]             src_q, src_d;
  logic [FW-1:0]             tgt_q, tgt_d;
  logic [pds_pkg::PRE_W-1:0] pre_q, pre_d;
  logic [FW-1:0]             fplli_q, fplli_d;
  logic [PW-1:0]             d1_q, d1_d;
  logic [PW-1:0]             d2_q, d2_d;
  logic [MW-1:0]             m_q, m_d;
  logic [XW-1:0]             fvco_q, fvco_d;
  logic [MW-1:0]             best_m_q, best_m_d;
  logic [PW-1:0]             best_d1_q, best_d1_d;
  logic [PW-1:0]             best_d2_q, best_d2_d;
  logic [EW-1:0]             best_err_q, best_err_d;
  logic                      found_q, found_d;
  pds_pkg::status_e          status_q, status_d;

  logic [FW-1:0]             in_min;
  logic                      bad_range;
  logic                      below_min;
  logic [pds_pkg::PRE_W-1:0] pre_sat;
  logic [FW-1:0]             fpl_val;
  logic                      fpl_high;
  logic [pds_pkg::PROD_W-1:0] prod;
  logic [FW-1:0]             mul_a;
  logic [MW-1:0]             mul_b;
  logic [XW-1:0]             mul_p;
  logic                      m_out;
  logic                      vco_out;
  logic [FW-1:0]             fout;
  logic [FW-1:0]             err;
  logic                      better;
  logic                      exact;
  logic                      pair_skip;
  logic                      last_d2;
  logic                      last_pair;

  assign in_min    = (cfg_i.pll_in_min == '0) ? FW'(1) : cfg_i.pll_in_min;
  assign bad_range = (tgt_q > cfg_i.target_max) || (tgt_q < cfg_i.target_min) ||
                     (src_q == '0);
  assign below_min = (src_q < in_min);

  assign pre_sat  = (|div_rsp_i.quotient[DW-1:pds_pkg::PRE_W]) ? pds_pkg::PRE_MAX :
                    div_rsp_i.quotient[pds_pkg::PRE_W-1:0];
  assign fpl_val  = div_rsp_i.quotient[FW-1:0];
  assign fpl_high = (fpl_val > cfg_i.pll_in_max);

  assign prod = {3'b000, d1_q} * {3'b000, d2_q};

  // shared multiplier: target times divider product, then fplli times multiplier
  assign mul_a = (state_q == pds_pkg::S_VCO) ? fplli_q : tgt_q;
  assign mul_b = (state_q == pds_pkg::S_VCO) ? m_q : MW'(prod);
  assign mul_p = {{MW{1'b0}}, mul_a} * {{FW{1'b0}}, mul_b};

  assign m_out = (div_rsp_i.quotient < DW'(cfg_i.mult_min)) ||
                 (div_rsp_i.quotient > DW'(cfg_i.mult_max));
  assign vco_out = (fvco_q < XW'(cfg_i.vco_min)) || (fvco_q > XW'(cfg_i.vco_max));

  assign fout   = div_rsp_i.quotient[FW-1:0];
  assign err    = (fout >= tgt_q) ? (fout - tgt_q) : (tgt_q - fout);
  assign better = (err < {1'b0, best_err_q});
  assign exact  = (err == '0);

  assign pair_skip = (d2_q > d1_q);
  assign last_d2   = (d2_q >= d1_q);
  assign last_pair = last_d2 && (d1_q == pds_pkg::POST1_MAX);

  always_comb begin
    state_d = state_q;
    case (state_q)
      pds_pkg::S_IDLE:  if (in_valid_i) state_d = pds_pkg::S_CHECK;
      pds_pkg::S_CHECK: state_d = (bad_range || below_min) ? pds_pkg::S_OUT : pds_pkg::S_PRE;
      pds_pkg::S_PRE:   if (div_rsp_i.done) state_d = pds_pkg::S_FPL;
      pds_pkg::S_FPL: begin
        if (div_rsp_i.done) state_d = fpl_high ? pds_pkg::S_OUT : pds_pkg::S_MULT;
      end
      pds_pkg::S_MULT:  state_d = pair_skip ? pds_pkg::S_NEXT : pds_pkg::S_DIVM;
      pds_pkg::S_DIVM: begin
        if (div_rsp_i.done) state_d = m_out ? pds_pkg::S_NEXT : pds_pkg::S_VCO;
      end
      pds_pkg::S_VCO:   state_d = pds_pkg::S_VCHK;
      pds_pkg::S_VCHK:  state_d = vco_out ? pds_pkg::S_NEXT : pds_pkg::S_DIVF;
      pds_pkg::S_DIVF: begin
        if (div_rsp_i.done) state_d = (better && exact) ? pds_pkg::S_OUT : pds_pkg::S_NEXT;
      end
      pds_pkg::S_NEXT:  state_d = last_pair ? pds_pkg::S_OUT : pds_pkg::S_MULT;
      pds_pkg::S_OUT:   if (out_ready_i) state_d = pds_pkg::S_IDLE;
      default:          state_d = pds_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    div_req_o   = '0;
    src_d       = src_q;
    tgt_d       = tgt_q;
    pre_d       = pre_q;
    fplli_d     = fplli_q;
    d1_d        = d1_q;
    d2_d        = d2_q;
    m_d         = m_q;
    fvco_d      = fvco_q;
    best_m_d    = best_m_q;
    best_d1_d   = best_d1_q;
    best_d2_d   = best_d2_q;
    best_err_d  = best_err_q;
    found_d     = found_q;
    status_d    = status_q;
    case (state_q)
      pds_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          src_d = src_i;
          tgt_d = tgt_i;
        end
      end
      pds_pkg::S_CHECK: begin
        pre_d      = '0;
        best_m_d   = '0;
        best_d1_d  = '0;
        best_d2_d  = '0;
        best_err_d = pds_pkg::ERR_START;
        found_d    = 1'b0;
        if (bad_range) begin
          status_d   = pds_pkg::ST_RANGE;
          best_err_d = '0;
        end else if (below_min) begin
          status_d   = pds_pkg::ST_PLL_IN;
          best_err_d = '0;
        end else begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {src_q, {pds_pkg::ALIGN_W{1'b0}}};
          div_req_o.divisor  = in_min;
          div_req_o.steps    = pds_pkg::STEPS_NARROW;
        end
      end
      pds_pkg::S_PRE: begin
        if (div_rsp_i.done) begin
          pre_d              = pre_sat;
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {src_q, {pds_pkg::ALIGN_W{1'b0}}};
          div_req_o.divisor  = FW'(pre_sat);
          div_req_o.steps    = pds_pkg::STEPS_NARROW;
        end
      end
      pds_pkg::S_FPL: begin
        if (div_rsp_i.done) begin
          fplli_d = fpl_val;
          d1_d    = pds_pkg::POST1_MIN;
          d2_d    = pds_pkg::POST2_MIN;
          if (fpl_high) begin
            status_d   = pds_pkg::ST_PLL_IN;
            best_err_d = '0;
          end
        end
      end
      pds_pkg::S_MULT: begin
        if (!pair_skip) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = mul_p[DW-1:0];
          div_req_o.divisor  = fplli_q;
          div_req_o.steps    = pds_pkg::STEPS_WIDE;
        end
      end
      pds_pkg::S_DIVM: begin
        if (div_rsp_i.done && !m_out) m_d = div_rsp_i.quotient[MW-1:0];
      end
      pds_pkg::S_VCO: begin
        fvco_d = mul_p;
      end
      pds_pkg::S_VCHK: begin
        // vco fits 32 bits once it is inside the window
        if (!vco_out) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {fvco_q[FW-1:0], {pds_pkg::ALIGN_W{1'b0}}};
          div_req_o.divisor  = FW'(prod);
          div_req_o.steps    = pds_pkg::STEPS_NARROW;
        end
      end
      pds_pkg::S_DIVF: begin
        if (div_rsp_i.done && better) begin
          best_err_d = err[EW-1:0];
          best_m_d   = m_q;
          best_d1_d  = d1_q;
          best_d2_d  = d2_q;
          found_d    = 1'b1;
          if (exact) status_d = pds_pkg::ST_OK;
        end
      end
      pds_pkg::S_NEXT: begin
        if (last_d2) begin
          d1_d = d1_q + 1'b1;
          d2_d = pds_pkg::POST2_MIN;
        end else begin
          d2_d = d2_q + 1'b1;
        end
        if (last_pair) begin
          status_d = found_q ? pds_pkg::ST_OK : pds_pkg::ST_NO_SOL;
          if (!found_q) best_err_d = '0;
        end
      end
      pds_pkg::S_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pds_pkg::S_IDLE;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    tgt_q      <= tgt_d;
    pre_q      <= pre_d;
    fplli_q    <= fplli_d;
    d1_q       <= d1_d;
    d2_q       <= d2_d;
    m_q        <= m_d;
    fvco_q     <= fvco_d;
    best_m_q   <= best_m_d;
    best_d1_q  <= best_d1_d;
    best_d2_q  <= best_d2_d;
    best_err_q <= best_err_d;
    status_q   <= status_d;
  end

  assign res_o.status          = status_q;
  assign res_o.pre_divider     = pre_q;
  assign res_o.multiplier      = best_m_q;
  assign res_o.post_div_first  = best_d1_q;
  assign res_o.post_div_second = best_d2_q;
  assign res_o.freq_error      = best_err_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while a result is pending");

  a_ok_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_q == pds_pkg::ST_OK)) |->
      ((best_d1_q != '0) && (best_d2_q != '0) && (best_d2_q <= best_d1_q)))
    else $error("ok result without a valid divider pair");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> ((state_q == pds_pkg::S_PRE) || (state_q == pds_pkg::S_FPL) ||
                        (state_q == pds_pkg::S_DIVM) || (state_q == pds_pkg::S_DIVF)))
    else $error("divider finished outside a wait state");

endmodule

[rtl/core/pll_divider_search.sv]
`timescale 1ns / 1ps

// pll divider search
// s_axis carries one request: source and target frequency in Hz. the block
// checks target and source, derives the pre-divider and PLL input, then walks the
// 28 post-divider pairs and returns the best multiplier and pair on m_axis
// with the status in tuser.
// one request is worked at a time; s_axis_tready is high only while idle.
// every division runs on one shared radix-2 divider, one quotient bit per
// cycle (38 steps for the multiplier quotient, 32 for the others), and
// dominates latency. a pair whose multiplier is out of range skips the vco
// product and the output division, one whose vco is out of the window skips
// the output division. rejected requests leave after the range check or
// after the PLL input check, and an exact match stops the search early. the
// next request is taken in the cycle after the result leaves.
// the result sits in an output register until m_axis_tready takes it; a
// stalled receiver just holds the block in that state.
// configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i), to be
// written by the user only while idle; the block itself does not enforce this.
// reset restores the register defaults, idle, no result.
module pll_divider_search (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [63:0]                s_axis_tdata,   // source_freq, target_freq
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [63:0]                m_axis_tdata,   // pre_divider, multiplier,
                                                     // post_div_first, post_div_second,
                                                     // freq_error, zero pad
  output logic [1:0]                 m_axis_tuser,   // status
  input  logic                       cfg_we_i,
  input  logic [pds_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [pds_pkg::FREQ_W-1:0] cfg_data_i
);

  pds_pkg::cfg_t     cfg;
  pds_pkg::div_req_t div_req;
  pds_pkg::div_rsp_t div_rsp;
  pds_pkg::result_t  res;

  pds_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pds_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .src_i       (s_axis_tdata[31:0]),
    .tgt_i       (s_axis_tdata[63:32]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {1'b0, res.freq_error, res.post_div_second, res.post_div_first,
                         res.multiplier, res.pre_divider};

endmodule
